// File: rtl/core/mtom_pkg.sv
// Shared widths, constants and types of the Miller index to orientation matrix block.
package mtom_pkg;

  localparam int INDEX_BITS = 6;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_W      = 16;

  localparam int SQ_W = 2 * INDEX_BITS;
  localparam int SW   = 2 * SQ_W;
  localparam int XW   = 2 * INDEX_BITS + 1;
  localparam int AXW  = 2 * INDEX_BITS;
  localparam int QW   = FRAC_BITS + 2;
  localparam int RW   = SW + 2 * FRAC_BITS + 8;
  localparam int NST  = FRAC_BITS + 2;
  localparam int NL   = 9;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_PW    = $clog2(MQ_DEPTH);
  localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);

  typedef struct packed {
    logic [NL-1:0][AXW-1:0] ax;
    logic [NL-1:0]          neg;
    logic [SQ_W-1:0]        sp;
    logic [SQ_W-1:0]        sd;
    logic [SW-1:0]          spd;
    logic                   degen;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t data;
  } work_xfer_t;

  typedef struct packed {
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] acc;
    logic [QW-1:0]        q;
    logic [SW-1:0]        s;
    logic                 neg;
  } lane_t;

endpackage

// File: rtl/core/miller_to_orientation_matrix.sv
// Top level of the Miller index to orientation matrix block.
//
//   channel  | transfer when    | ports
//   ---------+------------------+---------------------------------------------
//   input    | push && !full    | in_plane_h/k/l, in_dir_u/v/w
//   result   | pop && !empty    | out_g00 .. out_g22, out_degenerate
//
// One index set is accepted every cycle while full is low, and after its transfer it passes through
// the second front stage, the queue write, the back load stage, then one pipeline stage per
// quotient bit (FRAC_BITS + 2) in the back square root and divide recurrence. Reset is
// synchronous and clears all valid state. A held result stalls the back pipeline; the
// four-entry queue lets the front keep accepting until it fills, and full then rises.
module miller_to_orientation_matrix (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_plane_h,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_plane_k,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_plane_l,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_dir_u,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_dir_v,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_dir_w,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [mtom_pkg::OUT_W-1:0]     out_g00,
  output logic signed [mtom_pkg::OUT_W-1:0]     out_g10,
  output logic signed [mtom_pkg::OUT_W-1:0]     out_g20,
  output logic signed [mtom_pkg::OUT_W-1:0]     out_g01,
  output logic signed [mtom_pkg::OUT_W-1:0]     out_g11,
  output logic signed [mtom_pkg::OUT_W-1:0]     out_g21,
  output logic signed [mtom_pkg::OUT_W-1:0]     out_g02,
  output logic signed [mtom_pkg::OUT_W-1:0]     out_g12,
  output logic signed [mtom_pkg::OUT_W-1:0]     out_g22,
  output logic                                  out_degenerate
);

  mtom_pkg::work_xfer_t                              mid_in;
  logic                                              mid_full;
  logic                                              mid_empty;
  logic                                              mid_pop;
  mtom_pkg::work_t                                   mid_data;
  logic                                              out_valid;
  logic [mtom_pkg::NL-1:0][mtom_pkg::OUT_W-1:0]      out_g;

  mtom_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_plane_h (in_plane_h),
    .in_plane_k (in_plane_k),
    .in_plane_l (in_plane_l),
    .in_dir_u   (in_dir_u),
    .in_dir_v   (in_dir_v),
    .in_dir_w   (in_dir_w),
    .mid_full   (mid_full),
    .mid_out    (mid_in)
  );

  mtom_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (mid_in),
    .wr_full  (mid_full),
    .rd       (mid_pop),
    .rd_empty (mid_empty),
    .rd_data  (mid_data)
  );

  mtom_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_data  (mid_data),
    .mid_pop   (mid_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_g     (out_g),
    .out_degen (out_degenerate)
  );

  assign empty   = !out_valid;
  assign out_g00 = $signed(out_g[0]);
  assign out_g10 = $signed(out_g[1]);
  assign out_g20 = $signed(out_g[2]);
  assign out_g01 = $signed(out_g[3]);
  assign out_g11 = $signed(out_g[4]);
  assign out_g21 = $signed(out_g[5]);
  assign out_g02 = $signed(out_g[6]);
  assign out_g12 = $signed(out_g[7]);
  assign out_g22 = $signed(out_g[8]);

endmodule

// File: rtl/core/mtom_front.sv
// Front part: takes index sets, forms squares, cross products and magnitudes.
module mtom_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_plane_h,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_plane_k,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_plane_l,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_dir_u,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_dir_v,
  input  logic signed [mtom_pkg::INDEX_BITS-1:0] in_dir_w,
  input  logic                                  mid_full,
  output mtom_pkg::work_xfer_t                  mid_out
);

  logic                                    en;
  logic                                    a_valid_r;
  logic                                    b_valid_r;
  logic [mtom_pkg::SQ_W-1:0]               sp_r, sd_r;
  logic [mtom_pkg::SQ_W-1:0]               sp_nxt, sd_nxt;
  logic signed [mtom_pkg::XW-1:0]          x_r   [mtom_pkg::NL];
  logic signed [mtom_pkg::XW-1:0]          x_nxt [mtom_pkg::NL];
  mtom_pkg::work_t                         work_r, work_nxt;

  assign en   = !b_valid_r || !mid_full;
  assign full = !en;

  always_comb begin
    logic signed [mtom_pkg::XW-1:0] h, k, l, u, v, w;
    h = mtom_pkg::XW'(in_plane_h);
    k = mtom_pkg::XW'(in_plane_k);
    l = mtom_pkg::XW'(in_plane_l);
    u = mtom_pkg::XW'(in_dir_u);
    v = mtom_pkg::XW'(in_dir_v);
    w = mtom_pkg::XW'(in_dir_w);
    sp_nxt = mtom_pkg::SQ_W'(h * h + k * k + l * l);
    sd_nxt = mtom_pkg::SQ_W'(u * u + v * v + w * w);
    x_nxt[0] = u;
    x_nxt[1] = v;
    x_nxt[2] = w;
    x_nxt[3] = mtom_pkg::XW'(k * w - l * v);
    x_nxt[4] = mtom_pkg::XW'(l * u - h * w);
    x_nxt[5] = mtom_pkg::XW'(h * v - k * u);
    x_nxt[6] = h;
    x_nxt[7] = k;
    x_nxt[8] = l;
  end

  always_comb begin
    logic signed [mtom_pkg::XW-1:0] mag;
    mag = '0;
    work_nxt.sp    = sp_r;
    work_nxt.sd    = sd_r;
    work_nxt.spd   = mtom_pkg::SW'(sp_r) * mtom_pkg::SW'(sd_r);
    work_nxt.degen = (sp_r == '0) || (sd_r == '0);
    for (int i = 0; i < mtom_pkg::NL; i++) begin
      mag = x_r[i][mtom_pkg::XW-1] ? -x_r[i] : x_r[i];
      work_nxt.ax[i]  = mag[mtom_pkg::AXW-1:0];
      work_nxt.neg[i] = x_r[i][mtom_pkg::XW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= push;
      b_valid_r <= a_valid_r;
    end
    if (en) begin
      sp_r   <= sp_nxt;
      sd_r   <= sd_nxt;
      x_r    <= x_nxt;
      work_r <= work_nxt;
    end
  end

  assign mid_out.valid = b_valid_r;
  assign mid_out.data  = work_r;

endmodule

// File: rtl/core/mtom_fifo.sv
// Short queue of classified work items between the front and back parts.
module mtom_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtom_pkg::work_xfer_t wr,
  output logic                 wr_full,
  input  logic                 rd,
  output logic                 rd_empty,
  output mtom_pkg::work_t      rd_data
);

  mtom_pkg::work_t             mem_r [mtom_pkg::MQ_DEPTH];
  logic [mtom_pkg::MQ_PW-1:0]  wp_r, rp_r;
  logic [mtom_pkg::MQ_CW-1:0]  cnt_r;
  logic                        do_wr, do_rd;

  assign wr_full  = (cnt_r == mtom_pkg::MQ_CW'(mtom_pkg::MQ_DEPTH));
  assign rd_empty = (cnt_r == '0);
  assign do_wr    = wr.valid && !wr_full;
  assign do_rd    = rd && !rd_empty;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == mtom_pkg::MQ_PW'(mtom_pkg::MQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == mtom_pkg::MQ_PW'(mtom_pkg::MQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + mtom_pkg::MQ_CW'(do_wr) - mtom_pkg::MQ_CW'(do_rd);
    end
    if (do_wr) begin
      mem_r[wp_r] <= wr.data;
    end
  end

endmodule

// File: rtl/core/mtom_back.sv
// Back part: pipelined digit recurrence for nine rounded quotients x / sqrt(s).
module mtom_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                mid_empty,
  input  mtom_pkg::work_t                     mid_data,
  output logic                                mid_pop,
  input  logic                                pop,
  output logic                                out_valid,
  output logic [mtom_pkg::NL-1:0][mtom_pkg::OUT_W-1:0] out_g,
  output logic                                out_degen
);

  logic                         en;
  logic                         valid_r [mtom_pkg::NST+1];
  logic                         degen_r [mtom_pkg::NST+1];
  mtom_pkg::lane_t [mtom_pkg::NL-1:0] st_r   [mtom_pkg::NST+1];
  mtom_pkg::lane_t [mtom_pkg::NL-1:0] st_nxt [mtom_pkg::NST+1];

  assign en      = !valid_r[mtom_pkg::NST] || pop;
  assign mid_pop = en && !mid_empty;

  always_comb begin
    logic [mtom_pkg::SW-1:0] sq;
    sq = '0;
    for (int i = 0; i < mtom_pkg::NL; i++) begin
      sq = mtom_pkg::SW'(mid_data.ax[i]) * mtom_pkg::SW'(mid_data.ax[i]);
      st_nxt[0][i].r   = $signed(mtom_pkg::RW'(sq)) <<< (2 * mtom_pkg::FRAC_BITS + 2);
      st_nxt[0][i].acc = '0;
      st_nxt[0][i].q   = '0;
      st_nxt[0][i].neg = mid_data.neg[i];
      if (i < 3) begin
        st_nxt[0][i].s = mtom_pkg::SW'(mid_data.sd);
      end else if (i < 6) begin
        st_nxt[0][i].s = mid_data.spd;
      end else begin
        st_nxt[0][i].s = mtom_pkg::SW'(mid_data.sp);
      end
    end
  end

  for (genvar j = 0; j < mtom_pkg::NST; j++) begin : g_step
    localparam int BIT = mtom_pkg::NST - 1 - j;
    always_comb begin
      logic signed [mtom_pkg::RW-1:0] sv;
      logic signed [mtom_pkg::RW-1:0] cost;
      sv = '0;
      cost = '0;
      for (int i = 0; i < mtom_pkg::NL; i++) begin
        sv   = $signed(mtom_pkg::RW'(st_r[j][i].s));
        cost = (st_r[j][i].acc <<< (BIT + 2)) - (st_r[j][i].acc <<< 1)
             + (sv <<< (2 * BIT + 2)) - (sv <<< (BIT + 2)) + sv;
        st_nxt[j+1][i] = st_r[j][i];
        if (cost <= st_r[j][i].r) begin
          st_nxt[j+1][i].r   = st_r[j][i].r - (st_r[j][i].acc <<< (BIT + 2))
                             - (sv <<< (2 * BIT + 2));
          st_nxt[j+1][i].acc = st_r[j][i].acc + (sv <<< (BIT + 1));
          st_nxt[j+1][i].q   = st_r[j][i].q | (mtom_pkg::QW'(1) << BIT);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= mtom_pkg::NST; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= mid_pop;
      for (int k = 1; k <= mtom_pkg::NST; k++) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
    if (en) begin
      degen_r[0] <= mid_data.degen;
      for (int k = 1; k <= mtom_pkg::NST; k++) begin
        degen_r[k] <= degen_r[k-1];
      end
      for (int k = 0; k <= mtom_pkg::NST; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_comb begin
    logic [mtom_pkg::OUT_W-1:0] mag;
    mag = '0;
    for (int i = 0; i < mtom_pkg::NL; i++) begin
      mag = mtom_pkg::OUT_W'(st_r[mtom_pkg::NST][i].q);
      if (degen_r[mtom_pkg::NST]) begin
        out_g[i] = '0;
      end else begin
        out_g[i] = st_r[mtom_pkg::NST][i].neg ? -mag : mag;
      end
    end
  end

  assign out_valid = valid_r[mtom_pkg::NST];
  assign out_degen = degen_r[mtom_pkg::NST];

endmodule
